>>> rtl/fsp_pkg.sv
// shared types and constants of the four-step phase extraction pipeline
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    // cordic iteration count, operand prescale and angle accumulator format
    localparam int ITERS    = 26;
    localparam int PRESCALE = 24;
    localparam int ACC_BITS = 30;
    localparam int Z_BITS   = 35;
    localparam int OUT_BITS = 16;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // atan(2^-i) in q30, rounded to nearest
    localparam logic [ACC_BITS-1:0] ATAN_TAB [ITERS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32
    };

    // how the final phase is chosen
    typedef enum logic [2:0] {
        SP_CORDIC   = 3'd0,
        SP_ZERO     = 3'd1,
        SP_PI       = 3'd2,
        SP_POS_HALF = 3'd3,
        SP_NEG_HALF = 3'd4
    } t_sp_code;

    typedef struct packed {
        logic     valid;
        t_sp_code sp;
    } t_ctl;

endpackage

`default_nettype wire

>>> rtl/four_step_phase_extraction_unit.sv
// top level: four-step phase extraction, atan2(s3-s1, s0-s2) through a pipelined cordic
//
//   channel   direction  handshake            payload
//   pixel in  input      i_start / o_busy     i_sample_0 .. i_sample_3
//   phase out output     o_valid (strobe)     o_phase
//
// one pixel per clock, every clock; o_busy stays low
// pipeline: two prep stages, 26 cordic stages (one iteration each),
// one round and clamp stage
// synchronous active-low reset clears the valid bits; data registers are not reset
// nothing stalls: each result is shown for one cycle with o_valid high
`timescale 1ns / 1ps
`default_nettype none

module four_step_phase_extraction_unit
    import fsp_pkg::*;
#(
    parameter int SAMPLE_BITS     = 12,
    parameter int PHASE_FRAC_BITS = 13
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_0,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_1,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_2,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_3,
    output logic                         o_valid,
    output logic signed [OUT_BITS-1:0]   o_phase
);

    localparam int W   = SAMPLE_BITS + 27;
    localparam int LAT = 2 + ITERS + 1;

    t_ctl                     s_ctl [ITERS+1];
    logic signed [W-1:0]      s_x   [ITERS+1];
    logic signed [W-1:0]      s_y   [ITERS+1];
    logic signed [Z_BITS-1:0] s_z   [ITERS+1];
    logic [OUT_BITS-1:0]      s_phase;

    assign o_busy = 1'b0;

    fsp_prep #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .W          (W)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_start),
        .i_sample_0(i_sample_0),
        .i_sample_1(i_sample_1),
        .i_sample_2(i_sample_2),
        .i_sample_3(i_sample_3),
        .o_ctl     (s_ctl[0]),
        .o_x       (s_x[0]),
        .o_y       (s_y[0]),
        .o_z       (s_z[0])
    );

    for (genvar g = 0; g < ITERS; g++) begin : g_iter
        fsp_cordic_stage #(
            .W  (W),
            .IDX(g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (s_ctl[g]),
            .i_x    (s_x[g]),
            .i_y    (s_y[g]),
            .i_z    (s_z[g]),
            .o_ctl  (s_ctl[g+1]),
            .o_x    (s_x[g+1]),
            .o_y    (s_y[g+1]),
            .o_z    (s_z[g+1])
        );
    end

    fsp_post #(
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (s_ctl[ITERS]),
        .i_z    (s_z[ITERS]),
        .o_valid(o_valid),
        .o_phase(s_phase)
    );

    assign o_phase = $signed(s_phase);

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##LAT o_valid)
        else $error("accepted item did not produce a result");

    // no result without an item accepted the latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without an accepted item");

    // zero numerator with a non-negative denominator gives phase zero
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && (i_sample_3 == i_sample_1) && (i_sample_0 >= i_sample_2)
        |-> ##LAT (o_phase == '0))
        else $error("zero-numerator item gave a nonzero phase");

endmodule

`default_nettype wire

>>> rtl/fsp_prep.sv
// difference stage and quadrant prep: two register stages ahead of the cordic
`timescale 1ns / 1ps
`default_nettype none

module fsp_prep
    import fsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int W           = SAMPLE_BITS + 27
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_0,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_1,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_2,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_3,
    output t_ctl                         o_ctl,
    output logic signed [W-1:0]          o_x,
    output logic signed [W-1:0]          o_y,
    output logic signed [Z_BITS-1:0]     o_z
);

    localparam int D = SAMPLE_BITS + 1;
    localparam logic signed [Z_BITS-1:0] Z_PI = Z_BITS'(PI_Q30);

    logic                   r_va;
    logic signed [D-1:0]    r_num;
    logic signed [D-1:0]    r_den;
    logic signed [D-1:0]    n_num;
    logic signed [D-1:0]    n_den;

    t_ctl                   r_ctl;
    logic signed [W-1:0]    r_x;
    logic signed [W-1:0]    r_y;
    logic signed [Z_BITS-1:0] r_z;
    t_sp_code               n_sp;
    logic signed [D-1:0]    n_xa;
    logic signed [D-1:0]    n_ya;
    logic signed [W-1:0]    n_xw;
    logic signed [W-1:0]    n_yw;
    logic signed [Z_BITS-1:0] n_z;

    always_comb begin
        n_num = $signed({1'b0, i_sample_3}) - $signed({1'b0, i_sample_1});
        n_den = $signed({1'b0, i_sample_0}) - $signed({1'b0, i_sample_2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_num <= n_num;
        r_den <= n_den;
    end

    always_comb begin
        if (r_num == '0) begin
            n_sp = (r_den < 0) ? SP_PI : SP_ZERO;
        end else if (r_den == '0) begin
            n_sp = (r_num > 0) ? SP_POS_HALF : SP_NEG_HALF;
        end else begin
            n_sp = SP_CORDIC;
        end
        // left half plane: rotate by pi first
        if (r_den < 0) begin
            n_xa = -r_den;
            n_ya = -r_num;
            n_z  = (r_num > 0) ? Z_PI : -Z_PI;
        end else begin
            n_xa = r_den;
            n_ya = r_num;
            n_z  = '0;
        end
        n_xw = W'(n_xa);
        n_yw = W'(n_ya);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= r_va;
        end
        r_ctl.sp <= n_sp;
        r_x      <= n_xw <<< PRESCALE;
        r_y      <= n_yw <<< PRESCALE;
        r_z      <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

>>> rtl/fsp_cordic_stage.sv
// one registered vectoring cordic iteration
`timescale 1ns / 1ps
`default_nettype none

module fsp_cordic_stage
    import fsp_pkg::*;
#(
    parameter int W   = 39,
    parameter int IDX = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctl                     i_ctl,
    input  wire logic signed [W-1:0]      i_x,
    input  wire logic signed [W-1:0]      i_y,
    input  wire logic signed [Z_BITS-1:0] i_z,
    output t_ctl                          o_ctl,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [Z_BITS-1:0]      o_z
);

    localparam logic signed [Z_BITS-1:0] ANG = Z_BITS'(ATAN_TAB[IDX]);

    t_ctl                     r_ctl;
    logic signed [W-1:0]      r_x;
    logic signed [W-1:0]      r_y;
    logic signed [Z_BITS-1:0] r_z;
    logic signed [W-1:0]      n_xs;
    logic signed [W-1:0]      n_ys;

    // arithmetic shift floors, as the rotation needs
    assign n_xs = i_x >>> IDX;
    assign n_ys = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.sp <= i_ctl.sp;
        if (i_y > 0) begin
            r_x <= i_x + n_ys;
            r_y <= i_y - n_xs;
            r_z <= i_z + ANG;
        end else begin
            r_x <= i_x - n_ys;
            r_y <= i_y + n_xs;
            r_z <= i_z - ANG;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

>>> rtl/fsp_post.sv
// rounds the q30 angle, clamps to +-pi and selects the special-case phases
`timescale 1ns / 1ps
`default_nettype none

module fsp_post
    import fsp_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctl                     i_ctl,
    input  wire logic signed [Z_BITS-1:0] i_z,
    output logic                          o_valid,
    output logic [OUT_BITS-1:0]           o_phase
);

    localparam int SH     = ACC_BITS - PHASE_FRAC_BITS;
    localparam int R_BITS = Z_BITS - SH;
    localparam longint HALF_LSB = 64'sd1 <<< (SH - 1);
    localparam longint LIM_L    = (PI_Q30 + HALF_LSB) >>> SH;
    localparam longint HALF_L   = (HALF_PI_Q30 + HALF_LSB) >>> SH;
    localparam logic signed [R_BITS-1:0] LIM = R_BITS'(LIM_L);
    localparam logic [OUT_BITS-1:0] OUT_PI    = OUT_BITS'(LIM_L);
    localparam logic [OUT_BITS-1:0] OUT_HALF  = OUT_BITS'(HALF_L);
    localparam logic [OUT_BITS-1:0] OUT_NHALF = OUT_BITS'(-HALF_L);
    localparam logic signed [Z_BITS-1:0] Z_HALF = Z_BITS'(HALF_LSB);

    logic                       r_valid;
    logic [OUT_BITS-1:0]        r_phase;
    logic signed [Z_BITS-1:0]   n_zr;
    logic signed [R_BITS-1:0]   n_r;
    logic signed [R_BITS-1:0]   n_rc;
    logic signed [31:0]         n_r32;
    logic [OUT_BITS-1:0]        n_phase;

    always_comb begin
        n_zr = i_z + Z_HALF;
        n_r  = R_BITS'(n_zr >>> SH);
        if (n_r > LIM) begin
            n_rc = LIM;
        end else if (n_r < -LIM) begin
            n_rc = -LIM;
        end else begin
            n_rc = n_r;
        end
        n_r32 = 32'(n_rc);
        case (i_ctl.sp)
            SP_CORDIC:   n_phase = n_r32[OUT_BITS-1:0];
            SP_ZERO:     n_phase = '0;
            SP_PI:       n_phase = OUT_PI;
            SP_POS_HALF: n_phase = OUT_HALF;
            SP_NEG_HALF: n_phase = OUT_NHALF;
            default:     n_phase = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_phase <= n_phase;
    end

    assign o_valid = r_valid;
    assign o_phase = r_phase;

endmodule

`default_nettype wire
